FILE: hdl/gd3_pkg.sv
// Package for the 3x3 grayscale dilation block.
// Holds the item kind codes, register indexes and the control word passed
// from the position sequencer to the window stage. Depends on nothing.
`default_nettype none

package gd3_pkg;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes and widths.
    localparam int unsigned CFG_BITS      = 11;
    localparam int unsigned CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // Reset values and limits of the frame geometry.
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_BITS-1:0] HEIGHT_MAX   = 11'd1024;
    localparam logic [CFG_BITS-1:0] DIM_MIN      = 11'd2;

    // Decoded work for one request on its way to the window stage.
    typedef struct packed {
        logic emit_pre;   // emit the last pixel of the previous line first
        logic final_px;   // final output of the frame, no line store access
        logic adv;        // shift the window and update the line stores
        logic emit_post;  // emit the pixel centered one column back
        logic use_left;   // the leftmost window column is inside the image
        logic row_ge1;    // the middle line exists
        logic row_ge2;    // the upper line exists
    } ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/grayscale_dilation_3x3.sv
// 3x3 grayscale dilation over a raster pixel stream.
// Input stream: s_tdata carries one pixel, s_tuser says whether the request
// is a pixel or a drain request. After the last pixel of a frame, the source
// sends image_width + 1 drain requests to flush the last line; a pixel sent
// after the frame is full starts the next frame. Output stream: m_tdata is
// the maximum of the zero-padded 3x3 neighborhood, m_tlast marks the final
// pixel of a frame. Image size comes from the configuration write port and
// is clamped to 2..MAX_WIDTH by 2..1024.
// Throughput is one request per cycle while m_tready does not stall the
// output. The line store read is issued as a request is accepted; the
// request then waits in the stage register, and the window stage moves its
// result into the output register. In pixel terms an output lags its input
// by one line plus one pixel. A stall on m_tready holds the output register
// and the stage behind it, and s_tready falls only while a result waits.
// Reset clears the position to the start of a frame, the window to zero and
// the size registers to 640 by 480. The line stores need no clearing; each
// entry is written in a frame before its data is used.
`default_nettype none

module grayscale_dilation_3x3 #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned PIXEL_BITS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration port.
    input  wire logic                                cfg_we,
    input  wire logic [gd3_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [gd3_pkg::CFG_BITS-1:0]        cfg_data,
    // Input stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // pixel_value
    input  wire logic                                s_tuser,   // op
    // Output stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [((PIXEL_BITS+7)/8)*8-1:0]     m_tdata,   // dilated_value
    output logic                                     m_tlast
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned DB = ((PIXEL_BITS + 7) / 8) * 8;

    logic                    ce;
    logic                    in_fire;
    logic                    rd_en;
    logic [CW-1:0]           rd_addr;
    logic                    fwd_hit;
    logic                    s1_valid;
    gd3_pkg::ctrl_t          s1;
    logic [CW-1:0]           s1_col;
    logic [PIXEL_BITS-1:0]   s1_bot;
    logic                    wr_en;
    logic [2*PIXEL_BITS-1:0] wr_data;
    logic [2*PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0]   m_value;

    // The pipeline moves whenever the output register is free or being taken.
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;
    assign in_fire  = s_tvalid && ce;

    gd3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .ce           (ce),
        .in_fire      (in_fire),
        .in_op        (s_tuser),
        .in_pixel     (s_tdata[PIXEL_BITS-1:0]),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .fwd_hit      (fwd_hit),
        .s1_valid_reg (s1_valid),
        .s1_reg       (s1),
        .s1_col_reg   (s1_col),
        .s1_bot_reg   (s1_bot)
    );

    gd3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * PIXEL_BITS),
        .AW    (CW)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_col),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gd3_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .s1_valid    (s1_valid),
        .s1          (s1),
        .s1_bot      (s1_bot),
        .rd_fire     (rd_en),
        .fwd_hit     (fwd_hit),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_data     (wr_data),
        .m_valid_reg (m_tvalid),
        .m_value_reg (m_value),
        .m_last_reg  (m_tlast)
    );

    assign m_tdata = DB'(m_value);

`ifndef SYNTH
    // A read of the entry being written must take the forwarded data.
    a_fwd_on_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en && (rd_addr == s1_col)) |-> fwd_hit)
        else $error("line store collision without forwarding");

    // The final output of a frame never touches the line stores.
    a_final_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && s1.final_px) |-> !wr_en)
        else $error("final request wrote the line store");

    // With the output register empty the block must take requests.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire

FILE: hdl/gd3_line_mem.sv
// Line store RAM: one write port, one read port with registered read data.
// Each entry holds the upper and middle line pixels of one column.
// Depends on nothing.
`default_nettype none

module gd3_line_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned DW    = 16,
    parameter int unsigned AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // Write and registered read; a read of the address being written sees old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/gd3_ctrl.sv
// Position sequencer of the dilation block: configuration registers, raster
// position, request decode and the stage register in front of the window.
// Depends on gd3_pkg.
`default_nettype none

module gd3_ctrl #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned PIXEL_BITS = 8,
    parameter int unsigned CW         = 10
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [gd3_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  wire logic [gd3_pkg::CFG_BITS-1:0]         cfg_data,
    input  wire logic                                 ce,
    input  wire logic                                 in_fire,
    input  wire logic                                 in_op,
    input  wire logic [PIXEL_BITS-1:0]                in_pixel,
    output logic                                      rd_en,
    output logic      [CW-1:0]                        rd_addr,
    output logic                                      fwd_hit,
    output logic                                      s1_valid_reg,
    output gd3_pkg::ctrl_t                            s1_reg,
    output logic      [CW-1:0]                        s1_col_reg,
    output logic      [PIXEL_BITS-1:0]                s1_bot_reg
);

    localparam int unsigned WW = (CW + 1 > gd3_pkg::CFG_BITS) ? CW + 1 : gd3_pkg::CFG_BITS;
    localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

    logic [gd3_pkg::CFG_BITS-1:0] cfg_w_reg;
    logic [gd3_pkg::CFG_BITS-1:0] cfg_h_reg;
    logic [CW-1:0]                col_reg, col_next;
    logic [gd3_pkg::CFG_BITS-1:0] row_reg, row_next;

    logic [WW-1:0]                cfg_w_ext;
    logic [WW-1:0]                eff_w;
    logic [gd3_pkg::CFG_BITS-1:0] eff_h;
    logic                         is_drain;
    logic                         flush;
    logic                         ignore;
    logic                         restart;
    logic [CW-1:0]                col_e;
    logic [gd3_pkg::CFG_BITS-1:0] row_e;
    logic [WW-1:0]                col_inc;
    logic                         eol;
    gd3_pkg::ctrl_t               dec;
    logic [PIXEL_BITS-1:0]        bot;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= gd3_pkg::WIDTH_RESET;
            cfg_h_reg <= gd3_pkg::HEIGHT_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == gd3_pkg::CFG_IMAGE_WIDTH) begin
                cfg_w_reg <= cfg_data;
            end
            if (cfg_addr == gd3_pkg::CFG_IMAGE_HEIGHT) begin
                cfg_h_reg <= cfg_data;
            end
        end
    end

    // Clamp the frame geometry to the supported range.
    always_comb begin
        cfg_w_ext = WW'(cfg_w_reg);
        if (cfg_w_ext < WW'(gd3_pkg::DIM_MIN)) begin
            eff_w = WW'(gd3_pkg::DIM_MIN);
        end else if (cfg_w_ext > MAXW) begin
            eff_w = MAXW;
        end else begin
            eff_w = cfg_w_ext;
        end
        if (cfg_h_reg < gd3_pkg::DIM_MIN) begin
            eff_h = gd3_pkg::DIM_MIN;
        end else if (cfg_h_reg > gd3_pkg::HEIGHT_MAX) begin
            eff_h = gd3_pkg::HEIGHT_MAX;
        end else begin
            eff_h = cfg_h_reg;
        end
    end

    // Decode the request against the current raster position.
    always_comb begin
        is_drain = (in_op == gd3_pkg::OP_DRAIN);
        flush    = (row_reg >= eff_h);
        ignore   = is_drain && !flush;
        restart  = !is_drain && flush;
        col_e    = restart ? '0 : col_reg;
        row_e    = restart ? '0 : row_reg;
        col_inc  = WW'(col_e) + WW'(1);
        eol      = (col_inc >= eff_w);

        dec.final_px  = is_drain && (row_reg > eff_h);
        dec.adv       = !dec.final_px;
        dec.emit_pre  = (col_e == '0) && (row_e >= 11'd2);
        dec.emit_post = dec.adv && (col_e != '0) && (row_e >= 11'd1);
        dec.use_left  = (col_e >= CW'(2));
        dec.row_ge1   = (row_e >= 11'd1);
        dec.row_ge2   = (row_e >= 11'd2);
        bot           = is_drain ? '0 : in_pixel;

        if (dec.final_px) begin
            col_next = '0;
            row_next = '0;
        end else if (eol) begin
            col_next = '0;
            row_next = row_e + 11'd1;
        end else begin
            col_next = col_inc[CW-1:0];
            row_next = row_e;
        end
    end

    // Line store read and forwarding from the write of the request ahead.
    assign rd_en   = in_fire && !ignore && dec.adv;
    assign rd_addr = col_e;
    assign fwd_hit = s1_valid_reg && s1_reg.adv && (s1_col_reg == col_e);

    // Raster position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_fire && !ignore) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage register toward the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= in_fire && !ignore;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_reg     <= dec;
            s1_col_reg <= col_e;
            s1_bot_reg <= bot;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/gd3_window.sv
// Window stage of the dilation block: column maxima of the 3x3 window,
// line store write-back with forwarding, and the output register.
// Depends on gd3_pkg.
`default_nettype none

module gd3_window #(
    parameter int unsigned PIXEL_BITS = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    ce,
    input  wire logic                    s1_valid,
    input  wire gd3_pkg::ctrl_t          s1,
    input  wire logic [PIXEL_BITS-1:0]   s1_bot,
    input  wire logic                    rd_fire,
    input  wire logic                    fwd_hit,
    input  wire logic [2*PIXEL_BITS-1:0] rd_data,
    output logic                         wr_en,
    output logic      [2*PIXEL_BITS-1:0] wr_data,
    output logic                         m_valid_reg,
    output logic      [PIXEL_BITS-1:0]   m_value_reg,
    output logic                         m_last_reg
);

    logic                    fwd_hit_reg;
    logic [2*PIXEL_BITS-1:0] fwd_data_reg;
    logic [PIXEL_BITS-1:0]   cm1_reg, cm2_reg;

    logic [2*PIXEL_BITS-1:0] col_data;
    logic [PIXEL_BITS-1:0]   top, mid, new_cm, left;
    logic [PIXEL_BITS-1:0]   pre_val, post_a, post_val;
    logic                    step;

    // Column of the new pixel: upper and middle from the store, lower from the input.
    always_comb begin
        col_data = fwd_hit_reg ? fwd_data_reg : rd_data;
        top      = s1.row_ge2 ? col_data[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
        mid      = s1.row_ge1 ? col_data[PIXEL_BITS-1:0] : '0;
        new_cm   = (top > mid) ? top : mid;
        new_cm   = (s1_bot > new_cm) ? s1_bot : new_cm;
        step     = ce && s1_valid;
        wr_en    = step && s1.adv;
        wr_data  = {mid, s1_bot};
    end

    // Neighborhood maxima before and after the window shift.
    always_comb begin
        pre_val  = (cm2_reg > cm1_reg) ? cm2_reg : cm1_reg;
        left     = s1.use_left ? cm1_reg : '0;
        post_a   = (new_cm > cm2_reg) ? new_cm : cm2_reg;
        post_val = (left > post_a) ? left : post_a;
    end

    // Forwarded copy of a write to the entry read in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_fire) begin
            fwd_hit_reg <= fwd_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_fire) begin
            fwd_data_reg <= wr_data;
        end
    end

    // Window shift, holding only the maxima of the two newest columns.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cm1_reg <= '0;
            cm2_reg <= '0;
        end else if (wr_en) begin
            cm1_reg <= cm2_reg;
            cm2_reg <= new_cm;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= s1_valid && (s1.emit_pre || s1.emit_post);
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_value_reg <= s1.emit_pre ? pre_val : post_val;
            m_last_reg  <= s1.emit_pre && s1.final_px;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_grayscale_dilation_3x3.sv
// Self-checking testbench for the 3x3 grayscale dilation block.
// Uses gd3_pkg and grayscale_dilation_3x3. Frames of random pixels are run
// against a built-in raster predictor, with random idling on both streams.
`timescale 1ns / 1ps

module tb;

    // Corner and center test image, first pixel in the lowest byte.
    localparam logic [71:0] CORNER_PATTERN = 72'hAA_00_55_00_80_00_01_00_FF;
    localparam int unsigned LINE_DEPTH = 1024;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RESULT_WAIT_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } dilation_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [gd3_pkg::CFG_ADDR_BITS-1:0] cfg_addr = gd3_pkg::CFG_IMAGE_WIDTH;
    logic [gd3_pkg::CFG_BITS-1:0]      cfg_data = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata = 8'h00;            // pixel_value
    logic                              s_tuser = gd3_pkg::OP_PIXEL; // op
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [7:0]                        m_tdata;                    // dilated_value
    logic                              m_tlast;

    // Predictor state: geometry, line stores, window and raster position.
    logic [gd3_pkg::CFG_BITS-1:0] width_reg = gd3_pkg::WIDTH_RESET;
    logic [gd3_pkg::CFG_BITS-1:0] height_reg = gd3_pkg::HEIGHT_RESET;
    logic [7:0]          upper_line [LINE_DEPTH];
    logic [7:0]          middle_line [LINE_DEPTH];
    logic [7:0]          window_px [3][3];   // [column, oldest first][row, top first]
    int                  pos_col = 0;
    int                  pos_row = 0;

    dilation_t   expected_pixels [$];
    int unsigned mismatch_count = 0;
    int unsigned frame_items = 0;
    int unsigned sink_hold = 0;
    bit          sink_stall_on = 1'b0;
    bit          source_idle_on = 1'b0;

    grayscale_dilation_3x3 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int width_used();
        if (width_reg < gd3_pkg::DIM_MIN)
            return int'(gd3_pkg::DIM_MIN);
        if (width_reg > LINE_DEPTH)
            return int'(LINE_DEPTH);
        return int'(width_reg);
    endfunction

    function automatic int height_used();
        if (height_reg < gd3_pkg::DIM_MIN)
            return int'(gd3_pkg::DIM_MIN);
        if (height_reg > gd3_pkg::HEIGHT_MAX)
            return int'(gd3_pkg::HEIGHT_MAX);
        return int'(height_reg);
    endfunction

    function automatic logic [7:0] column_peak(int k);
        logic [7:0] m;
        m = window_px[k][0];
        if (window_px[k][1] > m)
            m = window_px[k][1];
        if (window_px[k][2] > m)
            m = window_px[k][2];
        return m;
    endfunction

    // One raster position, a real pixel or a zero pixel while flushing.
    // The center of each output sits one column behind the newest column.
    function automatic void advance_raster(logic [7:0] value, bit flushing, bit closing);
        int         c;
        int         r;
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
        logic [7:0] peak;
        c = pos_col;
        r = pos_row;
        // A new line first finishes the last pixel of the line two rows up.
        if (c == 0 && r >= 2) begin
            peak = column_peak(1);
            if (column_peak(2) > peak)
                peak = column_peak(2);
            expected_pixels.push_back(dilation_t'{value: peak, last: closing});
        end
        if (closing) begin
            pos_col = 0;
            pos_row = 0;
            return;
        end
        top = 8'h00;
        mid = 8'h00;
        bot = flushing ? 8'h00 : value;
        if (r >= 2)
            top = upper_line[c];
        if (r >= 1)
            mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = bot;
        for (int k = 0; k < 3; k++) begin
            window_px[0][k] = window_px[1][k];
            window_px[1][k] = window_px[2][k];
        end
        window_px[2][0] = top;
        window_px[2][1] = mid;
        window_px[2][2] = bot;
        if (c >= 1 && r >= 1) begin
            peak = column_peak(1);
            if (column_peak(2) > peak)
                peak = column_peak(2);
            if (c >= 2 && column_peak(0) > peak)
                peak = column_peak(0);
            expected_pixels.push_back(dilation_t'{value: peak, last: 1'b0});
        end
        if (c + 1 >= width_used()) begin
            pos_col = 0;
            pos_row = r + 1;
        end else begin
            pos_col = c + 1;
        end
    endfunction

    // A pixel past the frame's end starts a new frame; a drain only counts
    // once the frame is full.
    function automatic void predict_request(logic op, logic [7:0] value);
        if (op == gd3_pkg::OP_PIXEL) begin
            if (pos_row >= height_used()) begin
                pos_col = 0;
                pos_row = 0;
            end
            advance_raster(value, 1'b0, 1'b0);
        end else if (pos_row >= height_used()) begin
            advance_raster(8'h00, 1'b1, pos_row > height_used());
        end
    endfunction

    function automatic logic [7:0] pick_pixel(int unsigned mode);
        case (mode)
            1: return 8'($urandom_range(0, 15));
            2: return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            3: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends one request and predicts its results once it is accepted.
    // Valid stays high afterwards so that back-to-back requests need no bubble.
    task automatic send_request(input logic op, input logic [7:0] value);
        int unsigned gap;
        gap = source_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_request(op, value);
    endtask

    // Holds the source off until all predicted results are back or time runs out.
    task automatic wait_results_done();
        int unsigned waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_pixels.size());
            mismatch_count++;
            expected_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both size registers; only called while the block is idle.
    task automatic set_geometry(input logic [gd3_pkg::CFG_BITS-1:0] w,
                                input logic [gd3_pkg::CFG_BITS-1:0] h);
        cfg_we <= 1'b1;
        cfg_addr <= gd3_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge aclk);
        cfg_addr <= gd3_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    // With noise on, stray drains and full pauses are mixed into the pixels.
    task automatic send_pixels(input int n, input int unsigned mode, input bit noise);
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(0, 99) < 5)
                send_request(gd3_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
            if (noise && $urandom_range(0, 99) < 3)
                wait_results_done();
            send_request(gd3_pkg::OP_PIXEL, pick_pixel(mode));
        end
    endtask

    task automatic run_frame(input int unsigned mode, input int drains, input bit noise);
        send_pixels(width_used() * height_used(), mode, noise);
        for (int i = 0; i < drains; i++)
            send_request(gd3_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
        frame_items += width_used() * height_used() + drains;
    endtask

    // Sizes below the minimum clamp to a 2 by 2 image.
    task automatic test_clamped_small();
        source_idle_on = 1'b1;
        sink_stall_on = 1'b1;
        set_geometry(11'd0, 11'd1);
        run_frame(3, 3, 1'b0);
        wait_results_done();
        set_geometry(11'd1, 11'd0);
        run_frame(0, 3, 1'b0);
        wait_results_done();
    endtask

    // Peaks at corners and center, a stray drain mid-frame and extra drains.
    task automatic test_corner_peaks();
        set_geometry(11'd3, 11'd3);
        for (int i = 0; i < 9; i++) begin
            send_request(gd3_pkg::OP_PIXEL, CORNER_PATTERN[8*i +: 8]);
            if (i == 4)
                send_request(gd3_pkg::OP_DRAIN, 8'hFF);
        end
        for (int i = 0; i < 6; i++)
            send_request(gd3_pkg::OP_DRAIN, 8'h00);
        wait_results_done();
    endtask

    // A new frame that cuts a flush short drops the outputs not yet flushed.
    task automatic test_pixel_during_flush();
        set_geometry(11'd4, 11'd3);
        run_frame(0, 2, 1'b0);
        run_frame(2, 7, 1'b0);
        wait_results_done();
    endtask

    // Size changes in the middle of a frame act on the current position.
    task automatic test_mid_frame_resize();
        set_geometry(11'd8, 11'd5);
        send_pixels(19, 0, 1'b0);
        wait_results_done();
        set_geometry(11'd4, 11'd5);
        send_pixels(9, 0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_request(gd3_pkg::OP_DRAIN, 8'h00);
        wait_results_done();
        set_geometry(11'd5, 11'd6);
        send_pixels(15, 1, 1'b0);
        wait_results_done();
        set_geometry(11'd5, 11'd3);
        for (int i = 0; i < 6; i++)
            send_request(gd3_pkg::OP_DRAIN, 8'h00);
        wait_results_done();
    endtask

    // Sizes above the maximum clamp instead of wrapping: a long first line
    // gives no early line break, then a narrow width closes the frame.
    task automatic test_largest_geometry();
        source_idle_on = 1'b0;
        set_geometry(11'd2047, 11'd2047);
        send_pixels(40, 2, 1'b0);
        wait_results_done();
        set_geometry(11'd6, 11'd2047);
        send_pixels(13, 0, 1'b0);
        wait_results_done();
        set_geometry(11'd6, 11'd3);
        for (int i = 0; i < 7; i++)
            send_request(gd3_pkg::OP_DRAIN, 8'h00);
        wait_results_done();
    endtask

    // Random small frames with random content, sizes and flush lengths.
    task automatic test_random_frames();
        int unsigned start;
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int          drains;
        start = frame_items;
        while (frame_items - start < 650) begin
            sink_stall_on = ($urandom_range(0, 9) < 7);
            source_idle_on = ($urandom_range(0, 3) != 0);
            // Resize only at the start of a frame, where no stale line is read.
            if (pos_row == 0 && pos_col == 0 && $urandom_range(0, 99) < 60) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    w = $urandom_range(0, 1);
                else if (r < 75)
                    w = $urandom_range(2, 10);
                else if (r < 92)
                    w = $urandom_range(11, 40);
                else
                    w = $urandom_range(60, 130);
                if ($urandom_range(0, 9) == 0)
                    h = $urandom_range(0, 1);
                else if (w > 40)
                    h = $urandom_range(2, 3);
                else
                    h = $urandom_range(2, 6);
                wait_results_done();
                set_geometry(11'(w), 11'(h));
            end
            r = $urandom_range(0, 99);
            if (r < 75)
                drains = width_used() + 1;
            else if (r < 85)
                drains = width_used() + 1 + int'($urandom_range(1, 3));
            else
                drains = int'($urandom_range(0, width_used()));
            run_frame($urandom_range(0, 3), drains, 1'b1);
        end
        wait_results_done();
    endtask

    // Result sink with random stalls.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            m_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_stall_on && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            sink_hold <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Each accepted result is compared against the oldest prediction.
    always @(posedge aclk) begin : check_results
        dilation_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result dilated_value %02h frame_last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: dilated_value expected %02h actual %02h",
                             $time, want.value, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: frame_last expected %b actual %b",
                             $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_line[i] = 8'h00;
            middle_line[i] = 8'h00;
        end
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                window_px[i][k] = 8'h00;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_clamped_small();
        test_corner_peaks();
        test_pixel_during_flush();
        test_mid_frame_resize();
        test_largest_geometry();
        test_random_frames();
        wait_results_done();
        if (mismatch_count == 0)
            $display("grayscale_dilation_3x3 regression: pass");
        else
            $display("grayscale_dilation_3x3 regression: fail");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("grayscale_dilation_3x3 regression: fail");
        $finish;
    end

endmodule

FILE: files.f
hdl/gd3_pkg.sv
hdl/gd3_line_mem.sv
hdl/gd3_ctrl.sv
hdl/gd3_window.sv
hdl/grayscale_dilation_3x3.sv
tb/tb_grayscale_dilation_3x3.sv
